// File: rtl/input_blanking_window_timer_defines.svh
// assertion macros for the blanking window timer
`ifndef INPUT_BLANKING_WINDOW_TIMER_DEFINES_SVH
`define INPUT_BLANKING_WINDOW_TIMER_DEFINES_SVH

`ifndef SYNTH
`define IBWT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibwt assertion failed");
`define IBWT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibwt assertion failed");
`else
`define IBWT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define IBWT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/ibwt_pkg.sv
package ibwt_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [TIME_W-1:0] GUARD_RESET = 32'd1000;
    localparam logic [0:0] REG_GUARD = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_QUERY   = 3'd0,
        FUNC_TRANS   = 3'd1,
        FUNC_DISCON  = 3'd2,
        FUNC_CONNECT = 3'd3,
        FUNC_TIMEOUT = 3'd4,
        FUNC_CLEAR   = 3'd5
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] timeout_ms;
    } t_evt;

    // guard length and its triple, the series cap span
    typedef struct packed {
        logic [TIME_W-1:0] guard;
        logic [TIME_W-1:0] guard3;
    } t_guard;

    // wrap-safe "a before b"
    function automatic logic is_before(input logic [TIME_W-1:0] a,
                                       input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage

// File: rtl/ibwt_cfg.sv
module ibwt_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ibwt_pkg::ADDR_W-1:0]  paddr,
    input  logic [ibwt_pkg::DATA_W-1:0]  pwdata,
    output logic [ibwt_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ibwt_pkg::t_guard             o_guard
);

    logic [ibwt_pkg::TIME_W-1:0] r_guard;
    logic [ibwt_pkg::TIME_W-1:0] r_guard3;
    logic                        w_sel;
    logic                        w_wr;

    assign w_sel  = (paddr[ibwt_pkg::ADDR_W-1:2] == ibwt_pkg::REG_GUARD);
    assign w_wr   = psel && penable && pwrite && w_sel;
    assign pready = 1'b1;
    assign prdata = w_sel ? r_guard : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard  <= ibwt_pkg::GUARD_RESET;
            r_guard3 <= ibwt_pkg::GUARD_RESET + {ibwt_pkg::GUARD_RESET[30:0], 1'b0};
        end else if (w_wr) begin
            r_guard  <= pwdata;
            r_guard3 <= pwdata + {pwdata[30:0], 1'b0};
        end
    end

    assign o_guard.guard  = r_guard;
    assign o_guard.guard3 = r_guard3;

endmodule

// File: rtl/ibwt_core.sv
module ibwt_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  ibwt_pkg::t_evt               i_evt,
    input  ibwt_pkg::t_guard             i_guard,
    output logic                         o_active,
    output logic [ibwt_pkg::TIME_W-1:0]  o_remaining_ms
);

    logic [ibwt_pkg::TIME_W-1:0] r_deadline, n_deadline;
    logic                        r_series_open, n_series_open;
    logic [ibwt_pkg::TIME_W-1:0] r_series_start, n_series_start;

    logic [ibwt_pkg::TIME_W-1:0] w_now;
    logic [ibwt_pkg::TIME_W-1:0] w_start;
    logic [ibwt_pkg::TIME_W-1:0] w_cap;
    logic [ibwt_pkg::TIME_W-1:0] w_guard_end;
    logic [ibwt_pkg::TIME_W-1:0] w_target;
    logic [ibwt_pkg::TIME_W-1:0] w_cand;
    logic                        w_ext_en;
    logic                        w_len_zero;
    logic                        w_win_act;
    ibwt_pkg::t_func             w_func;

    assign w_now       = i_evt.now_ms;
    assign w_func      = ibwt_pkg::t_func'(i_evt.func);
    assign w_start     = r_series_open ? r_series_start : w_now;
    assign w_cap       = w_start + i_guard.guard3;
    assign w_guard_end = w_now + i_guard.guard;
    assign w_target    = ibwt_pkg::is_before(w_cap, w_guard_end) ? w_cap : w_guard_end;
    assign w_win_act   = (r_deadline != '0) && ibwt_pkg::is_before(w_now, r_deadline);

    always_comb begin
        n_deadline     = r_deadline;
        n_series_open  = r_series_open;
        n_series_start = r_series_start;
        w_ext_en       = 1'b0;
        w_cand         = w_guard_end;
        w_len_zero     = 1'b1;
        case (w_func)
            ibwt_pkg::FUNC_TRANS: begin
                n_series_open  = 1'b0;
                n_series_start = '0;
                w_ext_en       = 1'b1;
                w_cand         = w_guard_end;
                w_len_zero     = (i_guard.guard == '0);
            end
            ibwt_pkg::FUNC_DISCON: begin
                n_series_open  = 1'b1;
                n_series_start = w_start;
                w_ext_en       = ibwt_pkg::is_before(w_now, w_cap);
                // now + (target - now) is target itself
                w_cand         = w_target;
                w_len_zero     = (w_target == w_now);
            end
            ibwt_pkg::FUNC_CONNECT: begin
                n_series_open  = 1'b0;
                n_series_start = '0;
            end
            ibwt_pkg::FUNC_TIMEOUT: begin
                w_ext_en       = 1'b1;
                w_cand         = w_now + i_evt.timeout_ms;
                w_len_zero     = (i_evt.timeout_ms == '0);
            end
            ibwt_pkg::FUNC_CLEAR: begin
                n_deadline     = '0;
                n_series_open  = 1'b0;
                n_series_start = '0;
            end
            default: begin
            end
        endcase
        if (w_ext_en && !w_len_zero &&
            (!w_win_act || ibwt_pkg::is_before(r_deadline, w_cand))) begin
            n_deadline = w_cand;
        end
    end

    assign o_active       = (n_deadline != '0) && ibwt_pkg::is_before(w_now, n_deadline);
    assign o_remaining_ms = o_active ? (n_deadline - w_now) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline     <= '0;
            r_series_open  <= 1'b0;
            r_series_start <= '0;
        end else if (i_adv) begin
            r_deadline     <= n_deadline;
            r_series_open  <= n_series_open;
            r_series_start <= n_series_start;
        end
    end

endmodule

// File: rtl/input_blanking_window_timer.sv
// a word is taken into the input register; its result is then registered in the result register and shown
// throughput: one word per cycle while i_stall is low; state update and result come from the same combinational logic
// a stalled result register holds; the input register still takes one more word
// reset (synchronous, i_rst_n low): window inactive, no disconnect series,
// guard length 1000 ms, both registers empty
`include "input_blanking_window_timer_defines.svh"

module input_blanking_window_timer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ibwt_pkg::ADDR_W-1:0]  paddr,
    input  logic [ibwt_pkg::DATA_W-1:0]  pwdata,
    output logic [ibwt_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ibwt_pkg::FUNC_W-1:0]  i_func,
    input  logic [ibwt_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [ibwt_pkg::TIME_W-1:0]  i_timeout_ms,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_active,
    output logic [ibwt_pkg::TIME_W-1:0]  o_remaining_ms
);

    ibwt_pkg::t_guard            w_guard;
    ibwt_pkg::t_evt              r_evt;
    logic                        r_in_valid;
    logic                        r_out_valid;
    logic                        r_active;
    logic [ibwt_pkg::TIME_W-1:0] r_remaining;
    logic                        w_adv;
    logic                        w_take;
    logic                        w_active;
    logic [ibwt_pkg::TIME_W-1:0] w_remaining;

    ibwt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_guard (w_guard)
    );

    ibwt_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_evt          (r_evt),
        .i_guard        (w_guard),
        .o_active       (w_active),
        .o_remaining_ms (w_remaining)
    );

    // word moves into the result register when that register is free or drained
    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_adv;
    assign w_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_evt.func       <= i_func;
            r_evt.now_ms     <= i_now_ms;
            r_evt.timeout_ms <= i_timeout_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_active    <= w_active;
            r_remaining <= w_remaining;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_active       = r_active;
    assign o_remaining_ms = r_remaining;

    `IBWT_ASSERT_NEXT(a_clear_idle, i_clk, i_rst_n,
        w_adv && (r_evt.func == ibwt_pkg::FUNC_CLEAR), !o_active)
    `IBWT_ASSERT_SAME(a_idle_zero, i_clk, i_rst_n,
        o_valid && !o_active, o_remaining_ms == '0)
    `IBWT_ASSERT_SAME(a_stall_full, i_clk, i_rst_n,
        o_stall, r_in_valid && r_out_valid && i_stall)
    `IBWT_ASSERT_NEXT(a_adv_valid, i_clk, i_rst_n,
        w_adv, o_valid)

endmodule

// File: tb/tb_input_blanking_window_timer.sv
module tb_input_blanking_window_timer;

    localparam logic [ibwt_pkg::FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [ibwt_pkg::FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
    localparam logic [ibwt_pkg::ADDR_W-1:0] GUARD_ADDR    =
        ibwt_pkg::ADDR_W'(4 * ibwt_pkg::REG_GUARD);
    localparam logic [ibwt_pkg::ADDR_W-1:0] SPARE_ADDR    =
        ibwt_pkg::ADDR_W'(4 * (ibwt_pkg::REG_GUARD + 1));
    localparam logic [ibwt_pkg::TIME_W-1:0] CAP_GUARDS    = 32'd3;
    localparam int                          SETTLE_CYCLES = 8;
    localparam int                          STALL_LIMIT   = 4000;

    // predicts the blanking window and keeps the reports still owed by the block
    class blanking_scoreboard;
        typedef struct packed {
            logic                        active;
            logic [ibwt_pkg::TIME_W-1:0] remaining;
        } t_window_report;

        logic [ibwt_pkg::TIME_W-1:0] guard;
        logic [ibwt_pkg::TIME_W-1:0] deadline;
        logic                        in_series;
        logic [ibwt_pkg::TIME_W-1:0] series_t0;
        t_window_report              pending[$];
        int unsigned                 errors;

        function new();
            guard     = ibwt_pkg::GUARD_RESET;
            deadline  = '0;
            in_series = 1'b0;
            series_t0 = '0;
            errors    = 0;
        endfunction

        // wrap-safe ordering of two millisecond stamps
        function bit precedes(logic [ibwt_pkg::TIME_W-1:0] a,
                              logic [ibwt_pkg::TIME_W-1:0] b);
            logic [ibwt_pkg::TIME_W-1:0] d;
            d = a - b;
            return d[ibwt_pkg::TIME_W-1];
        endfunction

        function bit window_open(logic [ibwt_pkg::TIME_W-1:0] now);
            return deadline != '0 && precedes(now, deadline);
        endfunction

        function void lengthen(logic [ibwt_pkg::TIME_W-1:0] now,
                               logic [ibwt_pkg::TIME_W-1:0] len);
            logic [ibwt_pkg::TIME_W-1:0] cand;
            if (len == '0)
                return;
            cand = now + len;
            if (!window_open(now) || precedes(deadline, cand))
                deadline = cand;
        endfunction

        function void note_event(logic [ibwt_pkg::FUNC_W-1:0] f,
                                 logic [ibwt_pkg::TIME_W-1:0] now,
                                 logic [ibwt_pkg::TIME_W-1:0] tmo);
            logic [ibwt_pkg::TIME_W-1:0] cap;
            logic [ibwt_pkg::TIME_W-1:0] target;
            t_window_report              rep;
            case (f)
                ibwt_pkg::FUNC_TRANS: begin
                    in_series = 1'b0;
                    series_t0 = '0;
                    lengthen(now, guard);
                end
                ibwt_pkg::FUNC_DISCON: begin
                    if (!in_series) begin
                        in_series = 1'b1;
                        series_t0 = now;
                    end
                    cap = series_t0 + guard * CAP_GUARDS;
                    if (precedes(now, cap)) begin
                        target = now + guard;
                        if (precedes(cap, target))
                            target = cap;
                        lengthen(now, target - now);
                    end
                end
                ibwt_pkg::FUNC_CONNECT: begin
                    in_series = 1'b0;
                    series_t0 = '0;
                end
                ibwt_pkg::FUNC_TIMEOUT: lengthen(now, tmo);
                ibwt_pkg::FUNC_CLEAR: begin
                    deadline  = '0;
                    in_series = 1'b0;
                    series_t0 = '0;
                end
                default: ;
            endcase
            rep.active    = window_open(now);
            rep.remaining = rep.active ? deadline - now : '0;
            pending.push_back(rep);
        endfunction

        function void check_report(logic act, logic [ibwt_pkg::TIME_W-1:0] rem);
            t_window_report want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word: active %0b remaining %0d", $time, act, rem);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (act !== want.active) begin
                $display("%0t: active mismatch: expected %0b actual %0b",
                         $time, want.active, act);
                errors++;
            end
            if (rem !== want.remaining) begin
                $display("%0t: remaining_ms mismatch: expected %0d actual %0d",
                         $time, want.remaining, rem);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ibwt_pkg::ADDR_W-1:0]   paddr;
    logic [ibwt_pkg::DATA_W-1:0]   pwdata;
    logic [ibwt_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          i_valid;
    logic                          o_stall;
    logic [ibwt_pkg::FUNC_W-1:0]   i_func;
    logic [ibwt_pkg::TIME_W-1:0]   i_now_ms;
    logic [ibwt_pkg::TIME_W-1:0]   i_timeout_ms;
    logic                          o_valid;
    logic                          i_stall;
    logic                          o_active;
    logic [ibwt_pkg::TIME_W-1:0]   o_remaining_ms;

    blanking_scoreboard            board = new();
    int                            send_idle_pct = 0;
    int                            stall_pct = 0;
    int                            quiet_cycles = 0;
    logic [ibwt_pkg::TIME_W-1:0]   clock_ms;

    input_blanking_window_timer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_now_ms       (i_now_ms),
        .i_timeout_ms   (i_timeout_ms),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_active       (o_active),
        .o_remaining_ms (o_remaining_ms)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_report(o_active, o_remaining_ms);
    end

    // no word moving on either side for too long means the block is hung
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("input_blanking_window_timer test failed");
            $finish;
        end
    end

    task automatic idle_gap();
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_event(input logic [ibwt_pkg::FUNC_W-1:0] f,
                              input logic [ibwt_pkg::TIME_W-1:0] now,
                              input logic [ibwt_pkg::TIME_W-1:0] tmo);
        idle_gap();
        i_valid      <= 1'b1;
        i_func       <= f;
        i_now_ms     <= now;
        i_timeout_ms <= tmo;
        do @(posedge i_clk); while (o_stall);
        board.note_event(f, now, tmo);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ibwt_pkg::ADDR_W-1:0] a,
                             input logic [ibwt_pkg::DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (a == GUARD_ADDR)
            board.guard = d;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input logic [ibwt_pkg::ADDR_W-1:0] a,
                                  input logic [ibwt_pkg::DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: guard_ms readback mismatch: expected %0d actual %0d",
                     $time, want, prdata);
            board.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_guard(input logic [ibwt_pkg::TIME_W-1:0] g);
        apb_write(GUARD_ADDR, g);
        apb_read_check(GUARD_ADDR, g);
    endtask

    // mostly advancing time with disconnect bursts, plus jumps and odd timeouts
    task automatic run_random(input int n);
        int                          count;
        int                          pick;
        int                          burst;
        int                          k;
        logic [ibwt_pkg::TIME_W-1:0] span;
        logic [ibwt_pkg::TIME_W-1:0] tmo;
        logic [ibwt_pkg::FUNC_W-1:0] f;
        count = 0;
        while (count < n) begin
            span = (board.guard == '0 || board.guard > 100000) ? 32'd500
                                                               : board.guard / 2 + 1;
            if ($urandom_range(0, 99) < 5)
                clock_ms = $urandom();
            else
                clock_ms += $urandom_range(0, span);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                burst = $urandom_range(1, 8);
                repeat (burst) begin
                    send_event(ibwt_pkg::FUNC_DISCON, clock_ms, $urandom());
                    clock_ms += $urandom_range(0, span);
                end
                count += burst;
            end else begin
                if (pick < 45)      f = ibwt_pkg::FUNC_QUERY;
                else if (pick < 58) f = ibwt_pkg::FUNC_TRANS;
                else if (pick < 68) f = ibwt_pkg::FUNC_CONNECT;
                else if (pick < 88) f = ibwt_pkg::FUNC_TIMEOUT;
                else if (pick < 94) f = ibwt_pkg::FUNC_CLEAR;
                else if (pick < 97) f = FUNC_SPARE_LO;
                else                f = FUNC_SPARE_HI;
                tmo = $urandom();
                if (f == ibwt_pkg::FUNC_TIMEOUT) begin
                    k = $urandom_range(0, 9);
                    if (k == 0)      tmo = '0;
                    else if (k == 2) tmo = -clock_ms;   // candidate lands on zero
                    else if (k > 2)  tmo = $urandom_range(1, 3 * span);
                end
                send_event(f, clock_ms, tmo);
                count++;
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_valid      <= 1'b0;
        i_stall      <= 1'b0;
        i_func       <= ibwt_pkg::FUNC_QUERY;
        i_now_ms     <= '0;
        i_timeout_ms <= '0;
        clock_ms      = 32'hFFFF_0000;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, guard at its reset length
        send_event(ibwt_pkg::FUNC_QUERY,   32'd0,    32'd0);
        send_event(ibwt_pkg::FUNC_TIMEOUT, 32'd100,  32'd0);
        send_event(ibwt_pkg::FUNC_TIMEOUT, 32'd100,  32'd500);
        send_event(ibwt_pkg::FUNC_TIMEOUT, 32'd200,  32'd100);
        send_event(ibwt_pkg::FUNC_TRANS,   32'd300,  32'd0);
        send_event(ibwt_pkg::FUNC_DISCON,  32'd400,  32'd0);
        send_event(ibwt_pkg::FUNC_DISCON,  32'd1300, 32'd0);
        send_event(ibwt_pkg::FUNC_DISCON,  32'd3000, 32'd0);
        send_event(ibwt_pkg::FUNC_DISCON,  32'd3400, 32'd0);
        send_event(ibwt_pkg::FUNC_CONNECT, 32'd3500, 32'd0);
        send_event(ibwt_pkg::FUNC_DISCON,  32'd3600, 32'd0);
        send_event(ibwt_pkg::FUNC_CLEAR,   32'd3700, 32'd0);
        send_event(ibwt_pkg::FUNC_TIMEOUT, 32'hFFFF_FF00, 32'h0000_0100);
        send_event(ibwt_pkg::FUNC_TIMEOUT, 32'hFFFF_FF00, 32'h0000_0200);
        send_event(ibwt_pkg::FUNC_QUERY,   32'h0000_0050, 32'd0);
        send_event(FUNC_SPARE_LO,          32'h0000_0060, 32'hFFFF_FFFF);
        send_event(FUNC_SPARE_HI,          32'h0000_0070, 32'd0);
        send_event(ibwt_pkg::FUNC_TIMEOUT, 32'd0, 32'hFFFF_FFFF);
        send_event(ibwt_pkg::FUNC_TIMEOUT, 32'h0000_1000, 32'h7FFF_FFFF);
        send_event(ibwt_pkg::FUNC_TIMEOUT, 32'h0000_1000, 32'h8000_0000);
        send_event(ibwt_pkg::FUNC_TRANS,   32'h8000_0000, 32'd0);
        send_event(ibwt_pkg::FUNC_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(ibwt_pkg::FUNC_QUERY,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        set_guard(32'd5);
        run_random(200);
        drain();

        set_guard(32'd0);
        send_idle_pct = 48;
        run_random(150);
        drain();

        set_guard(32'hFFFF_FFFF);
        send_idle_pct = 0;
        stall_pct     = 48;
        run_random(150);
        drain();

        // a write past the only register must leave the guard alone
        set_guard(32'd1000);
        apb_write(SPARE_ADDR, 32'd7);
        apb_read_check(GUARD_ADDR, 32'd1000);
        send_idle_pct = 27;
        stall_pct     = 27;
        run_random(100);
        drain();
        run_random(100);
        drain();

        set_guard($urandom_range(1, 60000));
        send_idle_pct = 48;
        stall_pct     = 0;
        run_random(150);
        drain();

        // triple of this guard is exactly all ones
        set_guard(32'h5555_5555);
        send_idle_pct = 0;
        stall_pct     = 48;
        run_random(150);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("input_blanking_window_timer test passed");
        else
            $display("input_blanking_window_timer test failed");
        $finish;
    end

endmodule
